FILE: hdl/cxft_pkg.sv
// Package for the CRC-16/XMODEM frame trailer unit.
// Holds the word types, the nibble table and the CRC and delimiter helpers.
// No dependencies.
package cxft_pkg;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [7:0]  CR_CHAR  = 8'h0D;
   localparam logic [7:0]  DELIM_PAREN = 8'h28;
   localparam logic [7:0]  DELIM_CR    = 8'h0D;
   localparam logic [7:0]  DELIM_LF    = 8'h0A;
   localparam logic [3:0]  NIB_MASK    = 4'hF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  crc_high;
      logic [7:0]  crc_low;
      logic [7:0]  end_char;
      logic [15:0] raw_crc;
   } rsp_word_type;

   // handed from the CRC stage to the trailer stage
   typedef struct packed {
      logic        valid;
      logic [15:0] crc;
   } frame_end_type;

   // 16-entry nibble table of polynomial 0x1021
   function automatic logic [15:0] nib_table(input logic [3:0] idx);
      logic [15:0] r;
      begin
         case (idx)
            4'h0: r = 16'h0000;
            4'h1: r = 16'h1021;
            4'h2: r = 16'h2042;
            4'h3: r = 16'h3063;
            4'h4: r = 16'h4084;
            4'h5: r = 16'h50a5;
            4'h6: r = 16'h60c6;
            4'h7: r = 16'h70e7;
            4'h8: r = 16'h8108;
            4'h9: r = 16'h9129;
            4'hA: r = 16'ha14a;
            4'hB: r = 16'hb16b;
            4'hC: r = 16'hc18c;
            4'hD: r = 16'hd1ad;
            4'hE: r = 16'he1ce;
            4'hF: r = 16'hf1ef;
            default: r = 16'h0000;
         endcase
         return r;
      end
   endfunction

   function automatic logic [15:0] nibble_step(input logic [15:0] crc, input logic [3:0] nib);
      logic [3:0] idx;
      begin
         idx = (crc[15:12] ^ nib) & NIB_MASK;
         return {crc[11:0], 4'h0} ^ nib_table(idx);
      end
   endfunction

   // high nibble first
   function automatic logic [15:0] byte_step(input logic [15:0] crc, input logic [7:0] b);
      begin
         return nibble_step(nibble_step(crc, b[7:4]), b[3:0]);
      end
   endfunction

   function automatic logic [7:0] avoid_delim(input logic [7:0] b);
      begin
         if (b == DELIM_PAREN || b == DELIM_CR || b == DELIM_LF) begin
            return b + 8'd1;
         end
         return b;
      end
   endfunction

endpackage

FILE: hdl/crc16_xmodem_frame_trailer_unit.sv
// Top level of the CRC-16/XMODEM frame trailer unit.
// Instantiates cxft_crc_stage and cxft_trailer_stage; uses cxft_pkg.
//
// Takes one payload byte per cycle when not stalled, each with a last-byte
// mark, and keeps a running CRC-16 (poly 0x1021, init 0, no reflection, no
// final xor). The word that carries the mark gives one result word: high and
// low CRC bytes, each bumped by one if it equals 0x28, 0x0D or 0x0A, a
// carriage return and the raw CRC; the CRC then restarts at zero. Throughput
// is one byte per cycle when not stalled, set by the two-nibble table update
// between the input register and the CRC register. A last byte waits in the
// input register until the result register has room, which then loads the
// result. While the result register is held by rsp_stall, plain bytes keep
// flowing and only the next last byte waits, stalling the input behind it.
module crc16_xmodem_frame_trailer_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cxft_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cxft_pkg::rsp_word_type rsp_word
);

   cxft_pkg::frame_end_type frame_end;
   logic                    out_free;

   cxft_crc_stage u_crc (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .out_free  (out_free),
      .frame_end (frame_end)
   );

   cxft_trailer_stage u_trailer (
      .clock     (clock),
      .reset     (reset),
      .frame_end (frame_end),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   // a finished frame never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      frame_end.valid |-> out_free)
      else $error("frame end while result register busy");

   a_new_result_from_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(frame_end.valid))
      else $error("result word without a frame end");

   a_no_delim_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.crc_high != cxft_pkg::DELIM_PAREN &&
                     rsp_word.crc_high != cxft_pkg::DELIM_CR &&
                     rsp_word.crc_high != cxft_pkg::DELIM_LF))
      else $error("delimiter in high CRC byte");

   a_low_matches_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.crc_low == cxft_pkg::avoid_delim(rsp_word.raw_crc[7:0]))
      else $error("low CRC byte does not follow raw CRC");
`endif

endmodule

FILE: hdl/cxft_crc_stage.sv
// Input register and running CRC register of the frame trailer unit.
// Folds one byte per cycle into the CRC when not stalled; uses cxft_pkg.
module cxft_crc_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cxft_pkg::req_word_type req_word,
   input  logic                  out_free,
   output cxft_pkg::frame_end_type frame_end
);

   logic                   in_valid_ff, in_valid_in;
   cxft_pkg::req_word_type in_word_ff, in_word_in;
   logic [15:0]            crc_ff, crc_in;
   logic [15:0]            crc_next;
   logic                   move;
   logic                   accept;

   assign crc_next = cxft_pkg::byte_step(crc_ff, in_word_ff.data_byte);

   // plain bytes always move on; the last byte needs room in the result register
   assign move      = in_valid_ff && (!in_word_ff.last_byte || out_free);
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      crc_in      = crc_ff;
      if (move) begin
         in_valid_in = 1'b0;
         crc_in      = in_word_ff.last_byte ? 16'h0000 : crc_next;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         crc_ff      <= 16'h0000;
      end else begin
         in_valid_ff <= in_valid_in;
         crc_ff      <= crc_in;
      end
      in_word_ff <= in_word_in;
   end

   assign frame_end.valid = move && in_word_ff.last_byte;
   assign frame_end.crc   = crc_next;

endmodule

FILE: hdl/cxft_trailer_stage.sv
// Result register of the frame trailer unit: delimiter avoidance on the CRC
// bytes and the carriage return. Uses cxft_pkg.
module cxft_trailer_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  cxft_pkg::frame_end_type frame_end,
   output logic                    out_free,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cxft_pkg::rsp_word_type  rsp_word
);

   logic                   out_valid_ff, out_valid_in;
   cxft_pkg::rsp_word_type out_word_ff, out_word_in;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_word_in  = out_word_ff;
      if (frame_end.valid) begin
         out_valid_in         = 1'b1;
         out_word_in.crc_high = cxft_pkg::avoid_delim(frame_end.crc[15:8]);
         out_word_in.crc_low  = cxft_pkg::avoid_delim(frame_end.crc[7:0]);
         out_word_in.end_char = cxft_pkg::CR_CHAR;
         out_word_in.raw_crc  = frame_end.crc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
